[design/oqa_pkg.sv]
package oqa_pkg;

  localparam int CompW   = 16;
  localparam int ProdW   = 34;   // signed Hamilton product component
  localparam int MagW    = 33;   // |p| fits in 33 bits
  localparam int SumW    = 68;   // sum of four squares
  localparam int RootW   = 35;   // floor(sqrt(S)) fits in 35 bits
  localparam int NumW    = 47;   // |p| * 2^14
  localparam int QuotW   = 48;
  localparam logic signed [CompW-1:0] OneQ14 = 16'sd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ,
    ST_ZCHK,
    ST_ROOT,
    ST_DIV_LD,
    ST_DIV,
    ST_DIV_ST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_clr;
    logic       mul_step;
    logic       sq_step;
    logic       root_init;
    logic       root_step;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       commit;
  } dp_cmd_t;

  typedef struct packed {
    logic       sum_zero;
    logic       last_mul;
    logic       last_sq;
    logic       last_root;
    logic       last_div_bit;
    logic       last_comp;
  } dp_sts_t;

endpackage

[design/oqa_if.sv]
interface oqa_in_if;
  import oqa_pkg::*;
  logic valid;
  logic ready;
  logic signed [CompW-1:0] delta_w;
  logic signed [CompW-1:0] delta_x;
  logic signed [CompW-1:0] delta_y;
  logic signed [CompW-1:0] delta_z;
  modport source (output valid, delta_w, delta_x, delta_y, delta_z, input ready);
  modport sink (input valid, delta_w, delta_x, delta_y, delta_z, output ready);
endinterface

interface oqa_out_if;
  import oqa_pkg::*;
  logic valid;
  logic ready;
  logic signed [CompW-1:0] orient_w;
  logic signed [CompW-1:0] orient_x;
  logic signed [CompW-1:0] orient_y;
  logic signed [CompW-1:0] orient_z;
  logic zero_length;
  modport source (output valid, orient_w, orient_x, orient_y, orient_z, zero_length,
                  input ready);
  modport sink (input valid, orient_w, orient_x, orient_y, orient_z, zero_length,
                output ready);
endinterface

[design/orientation_quaternion_accumulator_top.sv]
// Flow from input beat to result beat: 16 multiply-accumulate
// steps, 4 squares, a zero check, 34 square-root bit steps and four
// restoring divides; zero length skips root and divide.
// One item at a time, set by the bit-serial root and divider: a new input is
// taken only once the last result has been taken, so a stalled result holds the input off.
// Reset (synchronous, rst_n low): orientation returns to identity, w = 1.0.
module orientation_quaternion_accumulator_top
  import oqa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  oqa_in_if.sink    in_ch,
  oqa_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  oqa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  oqa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .d_w       (in_ch.delta_w),
    .d_x       (in_ch.delta_x),
    .d_y       (in_ch.delta_y),
    .d_z       (in_ch.delta_z),
    .q_w       (out_ch.orient_w),
    .q_x       (out_ch.orient_x),
    .q_y       (out_ch.orient_y),
    .q_z       (out_ch.orient_z),
    .zero_flag (out_ch.zero_length)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.orient_w))
    else $error("result changed while stalled");

  a_zero_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_ch.zero_length)
    else $error("commit on zero length");

endmodule

[design/oqa_ctrl.sv]
module oqa_ctrl
  import oqa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.mul_clr = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.last_mul) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        if (sts.last_sq) state_nxt = ST_ZCHK;
      end
      ST_ZCHK: begin
        cmd.root_init = 1'b1;
        state_nxt = sts.sum_zero ? ST_OUT : ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.last_root) state_nxt = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        cmd.div_load = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.last_div_bit) state_nxt = ST_DIV_ST;
      end
      ST_DIV_ST: begin
        cmd.div_store = 1'b1;
        if (sts.last_comp) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_DIV_LD;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[design/oqa_dp.sv]
module oqa_dp
  import oqa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic signed [CompW-1:0] d_w,
  input  logic signed [CompW-1:0] d_x,
  input  logic signed [CompW-1:0] d_y,
  input  logic signed [CompW-1:0] d_z,
  output logic signed [CompW-1:0] q_w,
  output logic signed [CompW-1:0] q_x,
  output logic signed [CompW-1:0] q_y,
  output logic signed [CompW-1:0] q_z,
  output logic                    zero_flag
);

  logic signed [CompW-1:0] orient_r [4];
  logic signed [CompW-1:0] res_r [4];
  logic signed [CompW-1:0] delta_r [4];
  logic signed [ProdW-1:0] prod_r [4];
  logic [3:0]              mcnt_r;   // 16 product terms
  logic [1:0]              sq_cnt_r;
  logic [1:0]              comp_r;
  logic [SumW-1:0]         sum_r;
  logic [RootW-1:0]        root_r;
  logic [SumW+1:0]         rem_r;
  logic [5:0]              bit_r;
  logic [NumW-1:0]         num_r;
  logic [QuotW-1:0]        quot_r;
  logic [RootW:0]          drem_r;
  logic                    neg_r;
  logic                    zero_r;

  // one 16x16 multiply per cycle: row i picks output comp, col j picks d term
  logic [1:0]              mi, mj, ai;
  logic signed [CompW-1:0] ma, mb;
  logic signed [2*CompW-1:0] mprod;
  logic                    msub;

  assign mi = mcnt_r[3:2];
  assign mj = mcnt_r[1:0];

  always_comb begin
    // p[i] = sum over j of sign * a[ai] * b[j], ai = i xor j
    ai   = mi ^ mj;
    msub = 1'b0;
    case (mcnt_r)
      4'd1, 4'd2, 4'd3:    msub = 1'b1;   // w row: -ax bx -ay by -az bz
      4'd6:                msub = 1'b1;   // x row: -az by
      4'd11:               msub = 1'b1;   // y row: -ax bz
      4'd13:               msub = 1'b1;   // z row: -ay bx
      default:             msub = 1'b0;
    endcase
    ma    = orient_r[ai];
    mb    = delta_r[mj];
    mprod = ma * mb;
  end

  logic [MagW-1:0]   sq_mag;
  logic [2*MagW-1:0] sq_val;
  always_comb begin
    sq_mag = prod_r[sq_cnt_r][ProdW-1] ? MagW'(-prod_r[sq_cnt_r])
                                       : MagW'(prod_r[sq_cnt_r]);
    sq_val = sq_mag * sq_mag;
  end

  // restoring integer square root, one bit per cycle
  logic [SumW+1:0] r_try;
  logic [SumW+1:0] r_rem_sh;
  always_comb begin
    r_rem_sh = {rem_r[SumW-1:0], sum_r[SumW-1 -: 2]};
    r_try    = r_rem_sh - {{(SumW-RootW){1'b0}}, root_r, 2'b01};
  end

  // restoring divide of |p| * 2^14 by root, one bit per cycle
  logic [RootW:0] d_sh;
  logic [RootW:0] d_try;
  always_comb begin
    d_sh  = {drem_r[RootW-1:0], num_r[NumW-1]};
    d_try = d_sh - {1'b0, root_r};
  end

  logic signed [QuotW:0]   q_signed;
  logic signed [CompW-1:0] q_sat;
  always_comb begin
    q_signed = neg_r ? -$signed({1'b0, quot_r}) : $signed({1'b0, quot_r});
    if (q_signed > 49'sd32767)       q_sat = 16'sh7fff;
    else if (q_signed < -49'sd32768) q_sat = 16'sh8000;
    else                             q_sat = q_signed[CompW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r[0] <= OneQ14;
      orient_r[1] <= '0;
      orient_r[2] <= '0;
      orient_r[3] <= '0;
      mcnt_r      <= '0;
      sq_cnt_r    <= '0;
      comp_r      <= '0;
      bit_r       <= '0;
      zero_r      <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        delta_r[0] <= d_w;
        delta_r[1] <= d_x;
        delta_r[2] <= d_y;
        delta_r[3] <= d_z;
      end
      if (cmd.mul_clr) begin
        for (int k = 0; k < 4; k++) prod_r[k] <= '0;
        mcnt_r   <= '0;
        sq_cnt_r <= '0;
        sum_r    <= '0;
      end
      if (cmd.mul_step) begin
        prod_r[mi] <= msub ? prod_r[mi] - ProdW'(mprod) : prod_r[mi] + ProdW'(mprod);
        mcnt_r     <= mcnt_r + 4'd1;
      end
      if (cmd.sq_step) begin
        sum_r    <= sum_r + SumW'(sq_val);
        sq_cnt_r <= sq_cnt_r + 2'd1;
      end
      if (cmd.root_init) begin
        root_r <= '0;
        rem_r  <= '0;
        // one step per bit pair of the sum
        bit_r  <= 6'(SumW / 2 - 1);
        comp_r <= '0;
        zero_r <= (sum_r == '0);
      end
      if (cmd.root_step) begin
        sum_r <= {sum_r[SumW-3:0], 2'b00};
        if (!r_try[SumW+1]) begin
          rem_r  <= r_try;
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r  <= r_rem_sh;
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
        bit_r <= bit_r - 6'd1;
      end
      if (cmd.div_load) begin
        neg_r  <= prod_r[comp_r][ProdW-1];
        num_r  <= {(prod_r[comp_r][ProdW-1] ? MagW'(-prod_r[comp_r])
                                            : MagW'(prod_r[comp_r])), 14'd0};
        quot_r <= '0;
        drem_r <= '0;
        bit_r  <= 6'(NumW - 1);
      end
      if (cmd.div_step) begin
        num_r <= {num_r[NumW-2:0], 1'b0};
        if (!d_try[RootW]) begin
          drem_r <= d_try;
          quot_r <= {quot_r[QuotW-2:0], 1'b1};
        end else begin
          drem_r <= d_sh;
          quot_r <= {quot_r[QuotW-2:0], 1'b0};
        end
        bit_r <= bit_r - 6'd1;
      end
      if (cmd.div_store) begin
        res_r[comp_r] <= q_sat;
        comp_r        <= comp_r + 2'd1;
      end
      if (cmd.commit) begin
        orient_r[0] <= res_r[0];
        orient_r[1] <= res_r[1];
        orient_r[2] <= res_r[2];
        orient_r[3] <= q_sat;
      end
    end
  end

  assign sts.sum_zero     = (sum_r == '0);
  assign sts.last_mul     = (mcnt_r == 4'd15);
  assign sts.last_sq      = (sq_cnt_r == 2'd3);
  assign sts.last_root    = (bit_r == '0);
  assign sts.last_div_bit = (bit_r == '0);
  assign sts.last_comp    = (comp_r == 2'd3);

  assign q_w       = orient_r[0];
  assign q_x       = orient_r[1];
  assign q_y       = orient_r[2];
  assign q_z       = orient_r[3];
  assign zero_flag = zero_r;

endmodule
